FILE: rtl/core/maidenhead_locator_encoder_macros.svh
// assertion macros for the maidenhead locator encoder
`ifndef MAIDENHEAD_LOCATOR_ENCODER_MACROS_SVH
`define MAIDENHEAD_LOCATOR_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MLE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mle assertion failed");
`define MLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mle assertion failed");
`else
`define MLE_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define MLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/core/mle_pkg.sv
// types and constants shared by the maidenhead locator encoder
package mle_pkg;

  localparam int NUM_CELLS = 4;
  localparam int MAXQ_MAX  = 23;
  localparam int DIG_W     = 5;
  localparam int LON_U_W   = 21;
  localparam int LAT_U_W   = 20;

  localparam int LON_HALF_SPAN = 648000;
  localparam int LAT_HALF_SPAN = 324000;
  localparam int LON_OOR_LIMIT = 648004;
  localparam int LAT_OOR_LIMIT = 324004;

  localparam int unsigned LON_UNIT [NUM_CELLS] = '{72000, 7200, 300, 30};
  localparam int unsigned LAT_UNIT [NUM_CELLS] = '{36000, 3600, 150, 15};
  localparam int unsigned CELL_MAXQ [NUM_CELLS] = '{17, 9, 23, 9};

  localparam logic [6:0] ASCII_UPPER_A = 7'd65;
  localparam logic [6:0] ASCII_LOWER_A = 7'd97;
  localparam logic [5:0] ASCII_ZERO    = 6'd48;

  typedef struct packed {
    logic [LON_U_W-1:0]                lon_rem;
    logic [LAT_U_W-1:0]                lat_rem;
    logic [NUM_CELLS-1:0][DIG_W-1:0]   lon_dig;
    logic [NUM_CELLS-1:0][DIG_W-1:0]   lat_dig;
    logic                              oor;
  } mle_item_t;

endpackage

FILE: rtl/core/mle_front.sv
// input stage: range flag, saturation and offset to unsigned arcseconds
module mle_front import mle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [19:0] lat_i,
  input  logic signed [20:0] lon_i,
  output logic               valid_o,
  input  logic               ready_i,
  output mle_item_t          item_o
);

  logic signed [21:0] lon_s, lon_c;
  logic signed [20:0] lat_s, lat_c;
  mle_item_t          item_d, item_q;
  logic               valid_d, valid_q;

  always_comb begin
    lon_s = {lon_i[20], lon_i};
    lat_s = {lat_i[19], lat_i};
    if (lon_s < -LON_HALF_SPAN) begin
      lon_c = 22'(-LON_HALF_SPAN);
    end else if (lon_s > LON_HALF_SPAN - 1) begin
      lon_c = 22'(LON_HALF_SPAN - 1);
    end else begin
      lon_c = lon_s;
    end
    if (lat_s < -LAT_HALF_SPAN) begin
      lat_c = 21'(-LAT_HALF_SPAN);
    end else if (lat_s > LAT_HALF_SPAN - 1) begin
      lat_c = 21'(LAT_HALF_SPAN - 1);
    end else begin
      lat_c = lat_s;
    end
    item_d         = '0;
    item_d.lon_rem = LON_U_W'(lon_c + LON_HALF_SPAN);
    item_d.lat_rem = LAT_U_W'(lat_c + LAT_HALF_SPAN);
    item_d.oor     = (lon_s >= LON_OOR_LIMIT) || (lon_s <= -LON_OOR_LIMIT) ||
                     (lat_s >= LAT_OOR_LIMIT) || (lat_s <= -LAT_OOR_LIMIT);
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/core/mle_cell.sv
// one digit cell: takes one locator digit pair off the remainders
`include "maidenhead_locator_encoder_macros.svh"
module mle_cell import mle_pkg::*; #(
  parameter int unsigned SLOT = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  mle_item_t item_i,
  output logic      valid_o,
  input  logic      ready_i,
  output mle_item_t item_o
);

  logic [MAXQ_MAX-1:0] ge_lon, ge_lat;
  logic [DIG_W-1:0]    q_lon, q_lat;
  logic [LON_U_W-1:0]  sub_lon;
  logic [LAT_U_W-1:0]  sub_lat;
  mle_item_t           item_d, item_q;
  logic                valid_d, valid_q;

  always_comb begin
    for (int k = 1; k <= MAXQ_MAX; k++) begin
      ge_lon[k-1] = (k <= CELL_MAXQ[SLOT]) &&
                    (32'(item_i.lon_rem) >= 32'(k) * LON_UNIT[SLOT]);
      ge_lat[k-1] = (k <= CELL_MAXQ[SLOT]) &&
                    (32'(item_i.lat_rem) >= 32'(k) * LAT_UNIT[SLOT]);
    end
    q_lon   = DIG_W'($countones(ge_lon));
    q_lat   = DIG_W'($countones(ge_lat));
    sub_lon = '0;
    sub_lat = '0;
    for (int k = 1; k <= MAXQ_MAX; k++) begin
      if (q_lon == DIG_W'(k)) begin
        sub_lon = LON_U_W'(32'(k) * LON_UNIT[SLOT]);
      end
      if (q_lat == DIG_W'(k)) begin
        sub_lat = LAT_U_W'(32'(k) * LAT_UNIT[SLOT]);
      end
    end
    item_d               = item_i;
    item_d.lon_rem       = item_i.lon_rem - sub_lon;
    item_d.lat_rem       = item_i.lat_rem - sub_lat;
    item_d.lon_dig[SLOT] = q_lon;
    item_d.lat_dig[SLOT] = q_lat;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  `MLE_ASSERT_SAME(a_lon_rem_below_unit, clk_i, rst_ni, valid_q,
    32'(item_q.lon_rem) < LON_UNIT[SLOT])
  `MLE_ASSERT_SAME(a_dig_within_clamp, clk_i, rst_ni, valid_q,
    (32'(item_q.lon_dig[SLOT]) <= CELL_MAXQ[SLOT]) &&
    (32'(item_q.lat_dig[SLOT]) <= CELL_MAXQ[SLOT]))
  `MLE_ASSERT_NEXT(a_held_while_blocked, clk_i, rst_ni, valid_q && !ready_i,
    valid_q && $stable(item_q))

endmodule

FILE: rtl/core/maidenhead_locator_encoder.sv
// Maidenhead locator encoder: arcsecond position to 8-character locator
// usage:
//   input channel: in_valid_i with latitude_arcsec_i and longitude_arcsec_i,
//   a transaction completes on a clock edge with in_valid_i high and in_stall_o low.
//   output channel: out_valid_o with the eight ASCII characters and out_of_range_o,
//   a transaction completes on a clock edge with out_valid_o high and out_stall_i low.
//   an input passes one range and offset stage, then a chain of four digit
//   cells (field, square, subsquare, extended), each peeling one digit pair
//   off the remainders, before its result is valid.
//   throughput is one position per cycle while out_stall_i is low; each stage holds one
//   position, so bubbles close up while the receiver stalls.
//   with out_stall_i held high the chain fills, and after five positions
//   in_stall_o rises until results are taken again; the waiting result holds.
//   positions beyond the span saturate to its edges; out_of_range_o is set 4 arcsec out.
//   reset empties every stage; no result is pending after reset.
module maidenhead_locator_encoder import mle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [19:0] latitude_arcsec_i,
  input  logic signed [20:0] longitude_arcsec_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [6:0]         lon_field_char_o,
  output logic [6:0]         lat_field_char_o,
  output logic [5:0]         lon_square_char_o,
  output logic [5:0]         lat_square_char_o,
  output logic [6:0]         lon_subsquare_char_o,
  output logic [6:0]         lat_subsquare_char_o,
  output logic [5:0]         lon_extended_char_o,
  output logic [5:0]         lat_extended_char_o,
  output logic               out_of_range_o
);

  logic      front_ready;
  logic      valid_c [NUM_CELLS+1];
  logic      ready_c [NUM_CELLS+1];
  mle_item_t item_c  [NUM_CELLS+1];
  mle_item_t res;

  mle_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .lat_i   (latitude_arcsec_i),
    .lon_i   (longitude_arcsec_i),
    .valid_o (valid_c[0]),
    .ready_i (ready_c[0]),
    .item_o  (item_c[0])
  );

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    mle_cell #(
      .SLOT (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[g]),
      .ready_o (ready_c[g]),
      .item_i  (item_c[g]),
      .valid_o (valid_c[g+1]),
      .ready_i (ready_c[g+1]),
      .item_o  (item_c[g+1])
    );
  end

  assign ready_c[NUM_CELLS] = !out_stall_i;
  assign in_stall_o         = !front_ready;
  assign out_valid_o        = valid_c[NUM_CELLS];
  assign res                = item_c[NUM_CELLS];

  assign lon_field_char_o     = ASCII_UPPER_A + 7'(res.lon_dig[0]);
  assign lat_field_char_o     = ASCII_UPPER_A + 7'(res.lat_dig[0]);
  assign lon_square_char_o    = ASCII_ZERO + 6'(res.lon_dig[1]);
  assign lat_square_char_o    = ASCII_ZERO + 6'(res.lat_dig[1]);
  assign lon_subsquare_char_o = ASCII_LOWER_A + 7'(res.lon_dig[2]);
  assign lat_subsquare_char_o = ASCII_LOWER_A + 7'(res.lat_dig[2]);
  assign lon_extended_char_o  = ASCII_ZERO + 6'(res.lon_dig[3]);
  assign lat_extended_char_o  = ASCII_ZERO + 6'(res.lat_dig[3]);
  assign out_of_range_o       = res.oor;

endmodule
